### design/cit_pkg.sv
// Shared types, constants and lookup tables of the cell isosurface triangulator.
`timescale 1ns / 1ps
package cit_pkg;

  // Position coordinate width (signed, 8 fraction bits) and difference width
  localparam int CW = 16;
  localparam int DW = CW + 1;

  // The largest normalized cross product magnitude sits in [2^23, 2^24)
  localparam int NORM_MSB = 23;
  localparam int NMW      = NORM_MSB + 1;

  // Square root unit: one result bit per stage
  localparam int SQW      = 2 * NMW + 4;
  localparam int SQ_STEPS = NMW + 2;
  localparam int LENW     = NMW + 2;

  // Normal component divider: one quotient bit per stage
  localparam int DIV_STEPS = 15;
  localparam int DVW       = NMW + DIV_STEPS + 3;

  // Stages of the normal unit, from its diff inputs to its output register
  localparam int NORM_LAT = 8 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [7:0] ISO_RESET = 8'd128;

  // Reciprocal table: ceil(2^32 / (2*den)), den in 1..255
  localparam int RECIP_SHIFT = 32;

  typedef struct packed {
    logic [3*CW-1:0] corner_7_pos;
    logic [3*CW-1:0] corner_6_pos;
    logic [3*CW-1:0] corner_5_pos;
    logic [3*CW-1:0] corner_4_pos;
    logic [3*CW-1:0] corner_3_pos;
    logic [3*CW-1:0] corner_2_pos;
    logic [3*CW-1:0] corner_1_pos;
    logic [3*CW-1:0] corner_0_pos;
    logic [63:0]     corner_values;
  } cell_in_t;

  typedef struct packed {
    logic            last_of_cell;
    logic            triangle_valid;
    logic [2:0]      tetra_index;
    logic [47:0]     face_normal;
    logic [3*CW-1:0] vertex_c;
    logic [3*CW-1:0] vertex_b;
    logic [3*CW-1:0] vertex_a;
  } tri_out_t;

  // Sideband that travels with each item down the pipeline
  typedef struct packed {
    logic [2:0] tetra;
    logic       tval;
    logic       last;
  } side_t;

  typedef logic [31:0] recip_tab_t [256];

  // Corners of the six tetrahedra around the 0-7 diagonal
  localparam logic [2:0] TETRA_CORNER [6][4] = '{
    '{3'd0, 3'd1, 3'd3, 3'd7}, '{3'd0, 3'd1, 3'd5, 3'd7},
    '{3'd0, 3'd2, 3'd3, 3'd7}, '{3'd0, 3'd2, 3'd6, 3'd7},
    '{3'd0, 3'd4, 3'd5, 3'd7}, '{3'd0, 3'd4, 3'd6, 3'd7}
  };

  // Local edge pairs of the ten triangle shapes
  localparam logic [1:0] TRI_EDGES [10][6] = '{
    '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3},
    '{2'd1, 2'd2, 2'd1, 2'd3, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0},
    '{2'd3, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2},
    '{2'd1, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd3, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1},
    '{2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1},
    '{2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd3, 2'd2, 2'd2, 2'd0, 2'd3, 2'd1},
    '{2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1}
  };

  // Per inside code: first triangle shape and triangle count
  localparam logic [3:0] CASE_FIRST [16] = '{
    4'd0, 4'd0, 4'd1, 4'd4, 4'd2, 4'd6, 4'd8, 4'd3,
    4'd3, 4'd8, 4'd6, 4'd2, 4'd4, 4'd1, 4'd0, 4'd0
  };
  localparam logic [1:0] CASE_COUNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
  };

  // Builds the reciprocal table by long division at elaboration
  function automatic recip_tab_t make_recip();
    recip_tab_t  tab;
    logic [33:0] num;
    logic [10:0] rem;
    logic [33:0] q;
    logic [9:0]  dv;
    tab[0] = '0;
    for (int d = 1; d < 256; d++) begin
      dv  = 10'(2 * d);
      num = (34'd1 << 32) + 34'(dv) - 34'd1;
      rem = '0;
      q   = '0;
      for (int b = 33; b >= 0; b--) begin
        rem = {rem[9:0], num[b]};
        if (rem >= 11'(dv)) begin
          rem  = rem - 11'(dv);
          q[b] = 1'b1;
        end
      end
      tab[d] = q[31:0];
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = make_recip();

endpackage

### design/cit_normal.sv
// Face normal unit: cross product, normalization, square root and divide stages.
`timescale 1ns / 1ps
module cit_normal (
  input  logic                       clk,
  input  logic                       en,
  input  logic [3*cit_pkg::DW-1:0]   d0,
  input  logic [3*cit_pkg::DW-1:0]   d1,
  output logic [47:0]                normal
);

  localparam int DW   = cit_pkg::DW;
  localparam int PW   = 2 * DW;
  localparam int CXW  = PW + 1;
  localparam int GC   = (CXW + 7) / 8;
  localparam int GBW  = (GC > 1) ? $clog2(GC) : 1;
  localparam int PBW  = $clog2(GC * 8);
  localparam int SHW  = GC * 8 + cit_pkg::NMW;
  localparam int NMW  = cit_pkg::NMW;
  localparam int SQW  = cit_pkg::SQW;
  localparam int SQN  = cit_pkg::SQ_STEPS;
  localparam int DVN  = cit_pkg::DIV_STEPS;
  localparam int DVW  = cit_pkg::DVW;
  localparam int LENW = cit_pkg::LENW;
  localparam logic [PBW-1:0] MSBP = PBW'(cit_pkg::NORM_MSB);

  typedef struct packed {
    logic [2:0][NMW-1:0] m;
    logic [2:0]          neg;
    logic                zero;
  } ncar_t;

  // Input components
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  assign ax = d0[0 +: DW];
  assign ay = d0[DW +: DW];
  assign az = d0[2*DW +: DW];
  assign bx = d1[0 +: DW];
  assign by = d1[DW +: DW];
  assign bz = d1[2*DW +: DW];

  logic signed [PW-1:0]  pr1 [6];
  logic signed [CXW-1:0] c2 [3];
  logic [CXW-1:0]        m3 [3];
  logic [2:0]            neg3;
  logic                  zero3;
  logic [GC*8-1:0]       or3;
  logic [CXW-1:0]        m4 [3];
  logic [2:0]            neg4;
  logic                  zero4;
  logic [GC*8-1:0]       or4;
  logic [GBW-1:0]        g4;
  logic [CXW-1:0]        m5 [3];
  logic [2:0]            neg5;
  logic                  zero5;
  logic [PBW-1:0]        p5;
  ncar_t                 car6, car7;
  logic [2*NMW-1:0]      sqr7 [3];
  logic [SQW-1:0]        sq_s [SQN+1];
  logic [SQW-1:0]        sq_r [SQN+1];
  ncar_t                 sq_c [SQN+1];
  logic [DVW-1:0]        dv_rem [DVN+1][3];
  logic [DVN-1:0]        dv_q   [DVN+1][3];
  logic [DVW-1:0]        dv_d   [DVN+1];
  logic [2:0]            dv_neg [DVN+1];
  logic                  dv_zero [DVN+1];

  // Combinational helpers for the search, shift, sqrt and divide stages
  logic [GBW-1:0]        g_sel;
  logic [7:0]            byte_sel;
  logic [2:0]            b_sel;
  logic [SHW-1:0]        sh_ext [3];
  logic [SQW-1:0]        sq_bit [SQN];
  logic [SQW-1:0]        sq_t   [SQN];
  logic [SQW-1:0]        sq_sn  [SQN];
  logic [SQW-1:0]        sq_rn  [SQN];
  logic [DVW-1:0]        dv_sh  [DVN];
  logic [DVW-1:0]        dv_rn  [DVN][3];
  logic [DVN-1:0]        dv_qn  [DVN][3];
  logic [LENW-1:0]       len;
  logic [15:0]           comp [3];

  always_comb begin
    // highest nonzero byte group of the OR of magnitudes
    g_sel = '0;
    for (int g = 0; g < GC; g++) begin
      if (or3[g*8 +: 8] != 8'd0) g_sel = GBW'(g);
    end
    // highest set bit inside the chosen group
    byte_sel = or4[g4*8 +: 8];
    b_sel    = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_sel[b]) b_sel = 3'(b);
    end
    // shift every magnitude so the largest lands on the fixed top bit
    for (int i = 0; i < 3; i++) begin
      if (p5 >= MSBP) sh_ext[i] = SHW'(m5[i]) >> (p5 - MSBP);
      else            sh_ext[i] = SHW'(m5[i]) << (MSBP - p5);
    end
    // one root bit per stage
    for (int i = 0; i < SQN; i++) begin
      sq_bit[i] = SQW'(1) << (2 * (SQN - 1 - i));
      sq_t[i]   = sq_r[i] + sq_bit[i];
      if (sq_s[i] >= sq_t[i]) begin
        sq_sn[i] = sq_s[i] - sq_t[i];
        sq_rn[i] = (sq_r[i] >> 1) + sq_bit[i];
      end else begin
        sq_sn[i] = sq_s[i];
        sq_rn[i] = sq_r[i] >> 1;
      end
    end
    len = sq_r[SQN][LENW-1:0];
    // one quotient bit per stage
    for (int i = 0; i < DVN; i++) begin
      dv_sh[i] = dv_d[i] << (DVN - 1 - i);
      for (int k = 0; k < 3; k++) begin
        dv_qn[i][k] = dv_q[i][k];
        if (dv_rem[i][k] >= dv_sh[i]) begin
          dv_rn[i][k]             = dv_rem[i][k] - dv_sh[i];
          dv_qn[i][k][DVN-1-i]    = 1'b1;
        end else begin
          dv_rn[i][k] = dv_rem[i][k];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      comp[k] = dv_neg[DVN][k] ? (16'd0 - 16'(dv_q[DVN][k])) : 16'(dv_q[DVN][k]);
      if (dv_zero[DVN]) comp[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cross product partial products
      pr1[0] <= ay * bz;
      pr1[1] <= az * by;
      pr1[2] <= az * bx;
      pr1[3] <= ax * bz;
      pr1[4] <= ax * by;
      pr1[5] <= ay * bx;
      // cross product
      for (int i = 0; i < 3; i++) begin
        c2[i] <= CXW'(pr1[2*i]) - CXW'(pr1[2*i+1]);
      end
      // magnitudes and signs
      for (int i = 0; i < 3; i++) begin
        m3[i]   <= c2[i][CXW-1] ? CXW'(-c2[i]) : CXW'(c2[i]);
        neg3[i] <= c2[i][CXW-1];
      end
      zero3 <= (c2[0] == '0) && (c2[1] == '0) && (c2[2] == '0);
      or3   <= (GC*8)'((c2[0][CXW-1] ? CXW'(-c2[0]) : CXW'(c2[0]))
                     | (c2[1][CXW-1] ? CXW'(-c2[1]) : CXW'(c2[1]))
                     | (c2[2][CXW-1] ? CXW'(-c2[2]) : CXW'(c2[2])));
      // coarse leading-one search
      m4    <= m3;
      neg4  <= neg3;
      zero4 <= zero3;
      or4   <= or3;
      g4    <= g_sel;
      // fine leading-one search
      m5    <= m4;
      neg5  <= neg4;
      zero5 <= zero4;
      p5    <= PBW'({g4, 3'b000}) + PBW'(b_sel);
      // normalizing shift
      for (int i = 0; i < 3; i++) car6.m[i] <= sh_ext[i][NMW-1:0];
      car6.neg  <= neg5;
      car6.zero <= zero5;
      // squares
      for (int i = 0; i < 3; i++) sqr7[i] <= car6.m[i] * car6.m[i];
      car7 <= car6;
      // sum of squares
      sq_s[0] <= SQW'(sqr7[0]) + SQW'(sqr7[1]) + SQW'(sqr7[2]);
      sq_r[0] <= '0;
      sq_c[0] <= car7;
      // square root stages
      for (int i = 0; i < SQN; i++) begin
        sq_s[i+1] <= sq_sn[i];
        sq_r[i+1] <= sq_rn[i];
        sq_c[i+1] <= sq_c[i];
      end
      // divide operands: (m * 32768 + len) / (2 * len)
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= DVW'({sq_c[SQN].m[k], 15'd0}) + DVW'(len);
        dv_q[0][k]   <= '0;
      end
      dv_d[0]    <= DVW'({len, 1'b0});
      dv_neg[0]  <= sq_c[SQN].neg;
      dv_zero[0] <= sq_c[SQN].zero;
      // divide stages
      for (int i = 0; i < DVN; i++) begin
        dv_rem[i+1]  <= dv_rn[i];
        dv_q[i+1]    <= dv_qn[i];
        dv_d[i+1]    <= dv_d[i];
        dv_neg[i+1]  <= dv_neg[i];
        dv_zero[i+1] <= dv_zero[i];
      end
      // sign restore
      normal <= {comp[2], comp[1], comp[0]};
    end
  end

endmodule

### design/cell_isosurface_triangulator.sv
// Top level: cell sequencer, edge interpolation lanes and output stage.
// Throughput: one triangle per cycle while the output does not stall; a cell holds the
// sequencer for one issue per triangle (up to 12), or a single issue for an empty cell,
// so the next cell is taken in the cycle its last triangle issues.
// All stages advance together; a stall at the output freezes the whole pipeline.
// Reset clears the sequencer and all stage valid bits and sets iso_level to 128.
`timescale 1ns / 1ps
module cell_isosurface_triangulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cit_pkg::cell_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cit_pkg::tri_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  localparam int CW   = cit_pkg::CW;
  localparam int DW   = cit_pkg::DW;
  localparam int MGW  = DW + 8;
  localparam int NW   = MGW + 1;
  localparam int RS   = cit_pkg::RECIP_SHIFT;
  localparam int LAT  = 2 + cit_pkg::NORM_LAT;
  localparam int VOUT = 7;

  logic [7:0] iso_level;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= cit_pkg::ISO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iso_level <= cfg_data;
    end
  end

  // Pipeline enable and stage valid bits
  logic           en;
  logic           vld [1:LAT];
  cit_pkg::side_t side [1:LAT];
  assign en = out_ready || !vld[LAT];

  // Sequencer state
  logic            busy, empty;
  logic [11:0]     rem;
  logic [3:0]      codes [6];
  logic [63:0]     cval;
  logic [3*CW-1:0] cpos [8];

  logic [3*CW-1:0] in_pos [8];
  logic [3:0]      codes_new [6];
  logic [11:0]     mask_new;
  logic [3:0]      slot;
  logic            found, pick_last, issue, acc;
  logic [11:0]     rem_clear;
  logic [3:0]      cur_code, tri_sel;
  logic [2:0]      ca [3];
  logic [2:0]      cb [3];

  assign in_pos[0] = in_data.corner_0_pos;
  assign in_pos[1] = in_data.corner_1_pos;
  assign in_pos[2] = in_data.corner_2_pos;
  assign in_pos[3] = in_data.corner_3_pos;
  assign in_pos[4] = in_data.corner_4_pos;
  assign in_pos[5] = in_data.corner_5_pos;
  assign in_pos[6] = in_data.corner_6_pos;
  assign in_pos[7] = in_data.corner_7_pos;

  // Inside codes and triangle slot mask of the incoming cell
  always_comb begin
    for (int t = 0; t < 6; t++) begin
      for (int k = 0; k < 4; k++) begin
        codes_new[t][k] =
          in_data.corner_values[8*cit_pkg::TETRA_CORNER[t][k] +: 8] > iso_level;
      end
      mask_new[2*t]   = cit_pkg::CASE_COUNT[codes_new[t]] > 2'd0;
      mask_new[2*t+1] = cit_pkg::CASE_COUNT[codes_new[t]] > 2'd1;
    end
  end

  // Pick the next triangle slot and its edge corners
  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (rem[i] && !found) begin
        slot  = 4'(i);
        found = 1'b1;
      end
    end
    rem_clear = rem & ~(12'd1 << slot);
    pick_last = empty || (rem_clear == 12'd0);
    cur_code  = codes[slot[3:1]];
    tri_sel   = cit_pkg::CASE_FIRST[cur_code] + 4'(slot[0]);
    for (int e = 0; e < 3; e++) begin
      ca[e] = cit_pkg::TETRA_CORNER[slot[3:1]][cit_pkg::TRI_EDGES[tri_sel][2*e]];
      cb[e] = cit_pkg::TETRA_CORNER[slot[3:1]][cit_pkg::TRI_EDGES[tri_sel][2*e+1]];
    end
  end

  assign issue    = busy && en;
  assign in_ready = !busy || (en && pick_last);
  assign acc      = in_valid && in_ready;

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      empty <= 1'b0;
      rem   <= '0;
    end else if (acc) begin
      busy  <= 1'b1;
      empty <= (mask_new == 12'd0);
      rem   <= mask_new;
    end else if (issue && pick_last) begin
      busy <= 1'b0;
    end else if (issue) begin
      rem <= rem_clear;
    end
  end

  // Held cell payload
  always_ff @(posedge clk) begin
    if (acc) begin
      cval  <= in_data.corner_values;
      cpos  <= in_pos;
      codes <= codes_new;
    end
  end

  // Valid bits and sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LAT; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[1] <= busy;
      for (int s = 2; s <= LAT; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1].tetra <= slot[3:1];
      side[1].tval  <= !empty;
      side[1].last  <= pick_last;
      if (empty) side[1].tetra <= '0;
      for (int s = 2; s <= LAT; s++) side[s] <= side[s-1];
    end
  end

  // Stage registers of the interpolation lanes (lane = edge * 3 + axis)
  logic [3*CW-1:0]      s1_pa [3];
  logic [3*CW-1:0]      s1_pb [3];
  logic [7:0]           s1_va [3];
  logic [7:0]           s1_vb [3];
  logic signed [DW-1:0] s2_diff [9];
  logic [CW-1:0]        s2_a [9];
  logic [7:0]           s2_num [3];
  logic [7:0]           s2_den [3];
  logic [MGW-1:0]       s3_mag [9];
  logic                 s3_neg [9];
  logic [7:0]           s3_den [9];
  logic [CW-1:0]        s3_a [9];
  logic [NW-1:0]        s4_n [9];
  logic [31:0]          s4_r [9];
  logic [8:0]           s4_d [9];
  logic                 s4_neg [9];
  logic [CW-1:0]        s4_a [9];
  logic [NW-1:0]        s5_qe [9];
  logic [NW-1:0]        s5_n [9];
  logic [8:0]           s5_d [9];
  logic                 s5_neg [9];
  logic [CW-1:0]        s5_a [9];
  logic [NW-1:0]        s6_q [9];
  logic                 s6_neg [9];
  logic [CW-1:0]        s6_a [9];
  logic [9*CW-1:0]      vd [VOUT:LAT];

  logic [8:0]           num9 [3];
  logic [8:0]           den9 [3];
  logic [NW+RS-1:0]     nr5 [9];
  logic [NW+8:0]        qd6 [9];
  logic [9*CW-1:0]      v7;
  logic [DW-1:0]        sa7, qq7;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      num9[e] = {1'b0, iso_level} - {1'b0, s1_va[e]};
      den9[e] = {1'b0, s1_vb[e]} - {1'b0, s1_va[e]};
      if (den9[e][8]) begin
        num9[e] = 9'd0 - num9[e];
        den9[e] = 9'd0 - den9[e];
      end
    end
    for (int l = 0; l < 9; l++) begin
      nr5[l] = (NW+RS)'(s4_n[l]) * (NW+RS)'(s4_r[l]);
      qd6[l] = (NW+9)'(s5_qe[l]) * (NW+9)'(s5_d[l]);
    end
    v7  = '0;
    sa7 = '0;
    qq7 = '0;
    for (int l = 0; l < 9; l++) begin
      sa7 = {s6_a[l][CW-1], s6_a[l]};
      qq7 = s6_q[l][DW-1:0];
      v7[l*CW +: CW] = s6_neg[l] ? CW'(sa7 - qq7) : CW'(sa7 + qq7);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // corner selection
      for (int e = 0; e < 3; e++) begin
        s1_pa[e] <= cpos[ca[e]];
        s1_pb[e] <= cpos[cb[e]];
        s1_va[e] <= cval[8*ca[e] +: 8];
        s1_vb[e] <= cval[8*cb[e] +: 8];
      end
      // edge differences and weight terms
      for (int e = 0; e < 3; e++) begin
        for (int j = 0; j < 3; j++) begin
          s2_diff[e*3+j] <= {s1_pb[e][j*CW+CW-1], s1_pb[e][j*CW +: CW]}
                          - {s1_pa[e][j*CW+CW-1], s1_pa[e][j*CW +: CW]};
          s2_a[e*3+j]    <= s1_pa[e][j*CW +: CW];
        end
        s2_num[e] <= num9[e][7:0];
        s2_den[e] <= den9[e][7:0];
      end
      // offset magnitude: |p2 - p1| * weight numerator
      for (int e = 0; e < 3; e++) begin
        for (int j = 0; j < 3; j++) begin
          s3_mag[e*3+j] <= MGW'(s2_diff[e*3+j][DW-1] ? DW'(-s2_diff[e*3+j])
                                                      : DW'(s2_diff[e*3+j]))
                         * MGW'(s2_num[e]);
          s3_neg[e*3+j] <= s2_diff[e*3+j][DW-1];
          s3_den[e*3+j] <= s2_den[e];
          s3_a[e*3+j]   <= s2_a[e*3+j];
        end
      end
      // rounding numerator and reciprocal fetch
      for (int l = 0; l < 9; l++) begin
        s4_n[l]   <= {s3_mag[l], 1'b0} + NW'(s3_den[l]);
        s4_r[l]   <= cit_pkg::RECIP[s3_den[l]];
        s4_d[l]   <= {s3_den[l], 1'b0};
        s4_neg[l] <= s3_neg[l];
        s4_a[l]   <= s3_a[l];
      end
      // quotient estimate, at most one too large
      for (int l = 0; l < 9; l++) begin
        s5_qe[l]  <= nr5[l][NW+RS-1:RS];
        s5_n[l]   <= s4_n[l];
        s5_d[l]   <= s4_d[l];
        s5_neg[l] <= s4_neg[l];
        s5_a[l]   <= s4_a[l];
      end
      // quotient correction
      for (int l = 0; l < 9; l++) begin
        s6_q[l]   <= (qd6[l] > (NW+9)'(s5_n[l])) ? s5_qe[l] - NW'(1) : s5_qe[l];
        s6_neg[l] <= s5_neg[l];
        s6_a[l]   <= s5_a[l];
      end
      // vertex results and their delay line to the output
      vd[VOUT] <= v7;
      for (int s = VOUT + 1; s <= LAT; s++) vd[s] <= vd[s-1];
    end
  end

  // Normal from the edge differences of edges 0 and 1
  logic [3*DW-1:0] nd0, nd1;
  logic [47:0]     nrm;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nd0[j*DW +: DW] = s2_diff[j];
      nd1[j*DW +: DW] = s2_diff[3+j];
    end
  end

  cit_normal u_normal (
    .clk    (clk),
    .en     (en),
    .d0     (nd0),
    .d1     (nd1),
    .normal (nrm)
  );

  // Result item; the empty-cell marker carries zero fields
  assign out_valid = vld[LAT];
  always_comb begin
    out_data                = '0;
    out_data.last_of_cell   = side[LAT].last;
    out_data.triangle_valid = side[LAT].tval;
    if (side[LAT].tval) begin
      out_data.tetra_index = side[LAT].tetra;
      out_data.face_normal = nrm;
      out_data.vertex_a    = vd[LAT][0 +: 3*CW];
      out_data.vertex_b    = vd[LAT][3*CW +: 3*CW];
      out_data.vertex_c    = vd[LAT][6*CW +: 3*CW];
    end
  end

endmodule

### bench/testbench.sv
// Self-checking testbench for the cell isosurface triangulator.
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cit_pkg::cell_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cit_pkg::tri_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  cell_isosurface_triangulator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [7:0] iso_cur;
  cit_pkg::tri_out_t tri_queue[$];
  int         errors = 0;
  int         cells_sent = 0;
  int         tris_seen = 0;
  int         empty_seen = 0;
  bit         no_idle = 1'b0;
  bit         hold_out = 1'b0;

  // Triangle table in predictor form
  localparam int EDGE_TAB [10][6] = '{
    '{0,1,0,2,0,3}, '{1,2,1,3,1,0}, '{2,1,2,3,2,0}, '{3,0,3,1,3,2},
    '{1,3,1,2,3,0}, '{3,0,0,2,2,1}, '{0,3,3,2,2,1}, '{0,3,0,1,1,2},
    '{3,2,2,0,3,1}, '{0,1,0,2,3,1}
  };
  localparam int SHAPE_FIRST [16] = '{0,0,1,4,2,6,8,3,3,8,6,2,4,1,0,0};
  localparam int SHAPE_COUNT [16] = '{0,1,1,2,1,2,2,1,1,2,2,1,2,1,1,0};
  localparam int TET_CORNERS [6][4] = '{
    '{0,1,3,7}, '{0,1,5,7}, '{0,2,3,7}, '{0,2,6,7}, '{0,4,5,7}, '{0,4,6,7}
  };

  function automatic longint coord_of(cit_pkg::cell_in_t c, int k, int j);
    logic [47:0] p;
    p = c[64 + 48*k +: 48];
    return longint'(signed'(p[16*j +: 16]));
  endfunction

  // Edge interpolation, round to nearest with ties away from zero
  function automatic longint edge_point(longint a, longint b, longint va, longint vb,
                                        longint lvl);
    longint num, den, prod, mag, q;
    num = lvl - va;
    den = vb - va;
    if (den == 0) return a;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    prod = (b - a) * num;
    mag = prod < 0 ? -prod : prod;
    q = (2 * mag + den) / (2 * den);
    return a + (prod < 0 ? -q : q);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt >>= 2;
    while (bt != 0) begin
      if (s >= r + bt) begin
        s = s - (r + bt);
        r = (r >> 1) + bt;
      end else r >>= 1;
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic logic [47:0] unit_normal(longint d0[3], longint d1[3]);
    longint c[3];
    logic [63:0] m[3], mx, s, len, n;
    logic [47:0] res;
    c[0] = d0[1] * d1[2] - d0[2] * d1[1];
    c[1] = d0[2] * d1[0] - d0[0] * d1[2];
    c[2] = d0[0] * d1[1] - d0[1] * d1[0];
    mx = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return '0;
    while (mx >= (64'd1 << 24)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 23)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      n = (m[i] * 64'd32768 + len) / (2 * len);
      if (c[i] < 0) n = -n;
      res[16*i +: 16] = n[15:0];
    end
    return res;
  endfunction

  // Works out every triangle of one cell and queues it, or a marker if the cell has none
  task automatic triangulate_cell(cit_pkg::cell_in_t c);
    int cnt, code, sh, a, b;
    longint va, vb;
    longint d[2][3];
    cit_pkg::tri_out_t t;
    cnt = 0;
    for (int tt = 0; tt < 6; tt++) begin
      code = 0;
      for (int k = 0; k < 4; k++)
        if (c.corner_values[8*TET_CORNERS[tt][k] +: 8] > iso_cur) code |= 1 << k;
      for (int k = 0; k < SHAPE_COUNT[code]; k++) begin
        sh = SHAPE_FIRST[code] + k;
        t = '0;
        for (int e = 0; e < 3; e++) begin
          a = TET_CORNERS[tt][EDGE_TAB[sh][2*e]];
          b = TET_CORNERS[tt][EDGE_TAB[sh][2*e+1]];
          va = c.corner_values[8*a +: 8];
          vb = c.corner_values[8*b +: 8];
          for (int j = 0; j < 3; j++) begin
            longint v;
            v = edge_point(coord_of(c, a, j), coord_of(c, b, j), va, vb, iso_cur);
            t[48*e + 16*j +: 16] = v[15:0];
            if (e < 2) d[e][j] = coord_of(c, b, j) - coord_of(c, a, j);
          end
        end
        t.face_normal = unit_normal(d[0], d[1]);
        t.tetra_index = tt[2:0];
        t.triangle_valid = 1'b1;
        tri_queue.push_back(t);
        cnt++;
      end
    end
    if (cnt == 0) begin
      t = '0;
      t.last_of_cell = 1'b1;
      tri_queue.push_back(t);
    end else tri_queue[$].last_of_cell = 1'b1;
  endtask

  function automatic cit_pkg::cell_in_t random_cell();
    cit_pkg::cell_in_t c;
    for (int k = 0; k < 8; k++) begin
      // Mostly values near the level so many tetrahedra are cut
      if ($urandom_range(3) == 0) c.corner_values[8*k +: 8] = 8'($urandom);
      else c.corner_values[8*k +: 8] = 8'(int'(iso_cur) + $urandom_range(60) - 30);
      for (int j = 0; j < 3; j++)
        c[64 + 48*k + 16*j +: 16] = $urandom_range(7) == 0 ? 16'($urandom)
                                    : 16'($urandom_range(4095) - 2048);
    end
    return c;
  endfunction

  // Sends one cell and predicts its triangles; valid drops for a random gap before some items unless no_idle is set
  task automatic send_cell(cit_pkg::cell_in_t c);
    if (!no_idle && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    triangulate_cell(c);
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (tri_queue.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_level(logic [7:0] lvl);
    cfg_data <= lvl;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iso_cur = lvl;
  endtask

  // Receiver: random stalls, checks each triangle against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tri_queue.size() == 0) begin
          $error("unexpected triangle %h", out_data);
          errors++;
        end else begin
          cit_pkg::tri_out_t ex;
          ex = tri_queue.pop_front();
          if (out_data.vertex_a !== ex.vertex_a) begin
            $error("vertex_a exp %h got %h", ex.vertex_a, out_data.vertex_a); errors++; end
          if (out_data.vertex_b !== ex.vertex_b) begin
            $error("vertex_b exp %h got %h", ex.vertex_b, out_data.vertex_b); errors++; end
          if (out_data.vertex_c !== ex.vertex_c) begin
            $error("vertex_c exp %h got %h", ex.vertex_c, out_data.vertex_c); errors++; end
          if (out_data.face_normal !== ex.face_normal) begin
            $error("face_normal exp %h got %h", ex.face_normal, out_data.face_normal);
            errors++; end
          if (out_data.tetra_index !== ex.tetra_index) begin
            $error("tetra_index exp %0d got %0d", ex.tetra_index, out_data.tetra_index);
            errors++; end
          if (out_data.triangle_valid !== ex.triangle_valid) begin
            $error("triangle_valid exp %b got %b", ex.triangle_valid, out_data.triangle_valid);
            errors++; end
          if (out_data.last_of_cell !== ex.last_of_cell) begin
            $error("last_of_cell exp %b got %b", ex.last_of_cell, out_data.last_of_cell);
            errors++; end
          if (ex.triangle_valid) tris_seen++;
          else empty_seen++;
        end
      end
    end
  end

  // Ready pattern: bursts of stall, long hold-off on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_out || rst) out_ready <= 1'b0;
    else if (no_idle) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // Long receiver hold-off, counted here
  task automatic hold_receiver();
    hold_out = 1'b1;
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
  endtask

  // Watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    cit_pkg::cell_in_t voxel;
    bit                typed;
    cit_pkg::tri_out_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    logic [7:0] levels [5];
    levels = '{8'd0, 8'd255, 8'd77, 8'd200, 8'd128};
    iso_cur = cit_pkg::ISO_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cells give one marker whose fields are all zero but for last_of_cell
    r.typed = 1'b1;
    r.res = '0;
    r.res.last_of_cell = 1'b1;
    r.voxel = '0;
    rows.push_back(r);
    r.voxel = '1;
    rows.push_back(r);
    r.voxel = '0;
    r.voxel.corner_values = {8{8'd128}};  // equal to level counts as outside
    rows.push_back(r);
    // Single inside corners and mixed codes, extremes of positions
    r.typed = 1'b0;
    for (int k = 0; k < 8; k++) begin
      r.voxel = '0;
      r.voxel.corner_values[8*k +: 8] = 8'd255;
      for (int q = 0; q < 8; q++)
        r.voxel[64 + 48*q +: 48] = {16'(q[2] ? 16'h7fff : 16'h8000),
                                    16'(q[1] ? 16'h7fff : 16'h8000),
                                    16'(q[0] ? 16'h7fff : 16'h8000)};
      rows.push_back(r);
    end
    // Complement: all but one inside
    for (int k = 0; k < 8; k += 3) begin
      r.voxel = rows[3 + k].voxel;
      r.voxel.corner_values = ~r.voxel.corner_values;
      rows.push_back(r);
    end
    // Two-triangle codes, degenerate (coincident) corners
    r.voxel = '0;
    r.voxel.corner_values = 64'hff00ff00_ff00ff00;
    rows.push_back(r);
    r.voxel.corner_values = 64'h00ffff00_00ffff00;
    rows.push_back(r);
    r.voxel = '1;
    r.voxel.corner_values = 64'h0f1e2d3c_4b5a6978;
    rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send_cell(rows[i].voxel);
        if (tri_queue[$] !== rows[i].res) begin
          $error("typed empty-cell row %0d mismatches predictor", i);
          errors++;
        end
      end else send_cell(rows[i].voxel);
    end
    drain_block();

    // Random phases over several levels, extremes included
    foreach (levels[i]) begin
      write_level(levels[i]);
      if (i == 2) begin
        fork
          hold_receiver();
        join_none
        repeat (30) send_cell(random_cell());
      end
      repeat (50) send_cell(random_cell());
      drain_block();
    end
    // Closing stretch with no idling
    no_idle = 1'b1;
    repeat (30) send_cell(random_cell());
    drain_block();

    $display("Sent %0d cells in six level phases; checked %0d triangles and %0d empty markers.",
             cells_sent, tris_seen, empty_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### files.f
design/cit_pkg.sv
design/cit_normal.sv
design/cell_isosurface_triangulator.sv
bench/testbench.sv
